>>> hw/rtl/dest_addr_queue_assigner_defines.svh
// assertion macros for the destination address queue assigner
`ifndef DEST_ADDR_QUEUE_ASSIGNER_DEFINES_SVH
`define DEST_ADDR_QUEUE_ASSIGNER_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define DAQA_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("check failed");
// property whose consequence must hold in the cycle after the trigger
`define DAQA_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("check failed");
`else
`define DAQA_ASSERT_ALWAYS(label, expr)
`define DAQA_ASSERT_NEXT(label, trig, cons)
`endif

`endif

>>> hw/rtl/daqa_pkg.sv
package daqa_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int QIDX_W      = 6;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // item function codes
    localparam logic FUNC_CLASSIFY = 1'b0;
    localparam logic FUNC_CLEAR    = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_NEW     = 3'd1,
        ST_NOMATCH = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4
    } status_t;

    // control sequencer states
    typedef enum logic {
        S_IDLE,
        S_BUSY
    } state_t;

    // control broadcast to every cell in the row
    typedef struct packed {
        logic  look;       // capture compare result against look_addr
        addr_t look_addr;
        logic  ins;        // append wr_addr at the first free cell
        logic  clr;        // drop all entries
        addr_t wr_addr;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/dest_addr_queue_assigner.sv
// flow: on item accept the cell row captures the compare result; the decide and append
//   step then loads the result into the output register once the output is free;
//   in_stall is held while busy, so no new item is taken until the last result is registered
// reset: all cell valid bits and the entry count clear at once, table is empty;
//   stored addresses are not reset and are never read before written
`include "dest_addr_queue_assigner_defines.svh"

module dest_addr_queue_assigner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic        is_ipv4,
    input  logic [31:0] dst_addr,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  queue_index,
    output logic [2:0]  status
);

    daqa_pkg::state_t   state_reg;
    daqa_pkg::state_t   state_next;
    logic               func_reg;
    logic               ipv4_reg;
    daqa_pkg::addr_t    key_reg;
    daqa_pkg::cnt_t     entry_count_reg;
    daqa_pkg::cnt_t     entry_count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [5:0]         queue_index_reg;
    logic [5:0]         queue_index_next;
    daqa_pkg::status_t  status_reg;
    daqa_pkg::status_t  status_next;

    daqa_pkg::cell_ctrl_t              ctrl;
    logic [daqa_pkg::TABLE_DEPTH-1:0] valid_vec;
    logic [daqa_pkg::TABLE_DEPTH-1:0] match_vec;
    logic                             hit;
    daqa_pkg::idx_t                   hit_idx;
    logic                             in_accept;
    logic                             out_free;
    logic                             full;
    logic                             ld_new;
    logic [31:0]                      hit_idx_w;
    logic [31:0]                      cnt_w;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign full      = valid_vec[daqa_pkg::TABLE_DEPTH-1];
    assign hit_idx_w = 32'(hit_idx);
    assign cnt_w     = 32'(entry_count_reg);

    // row of cells, valid bits chained from slot zero upward
    for (genvar g = 0; g < daqa_pkg::TABLE_DEPTH; g++)
    begin : g_cell
        logic prev_v;
        if (g == 0)
        begin : g_head
            assign prev_v = 1'b1;
        end
        else
        begin : g_link
            assign prev_v = valid_vec[g-1];
        end
        daqa_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_valid (prev_v),
            .valid      (valid_vec[g]),
            .match      (match_vec[g])
        );
    end

    daqa_enc u_enc (
        .match_vec (match_vec),
        .hit       (hit),
        .idx       (hit_idx)
    );

    // sequencer: capture compare on accept, then decide and append once the output is free
    always_comb
    begin
        state_next       = state_reg;
        in_stall         = 1'b0;
        entry_count_next = entry_count_reg;
        out_valid_next   = out_valid_reg && out_stall;
        queue_index_next = queue_index_reg;
        status_next      = status_reg;
        ld_new           = 1'b0;
        ctrl.look        = 1'b0;
        ctrl.look_addr   = dst_addr;
        ctrl.ins         = 1'b0;
        ctrl.clr         = 1'b0;
        ctrl.wr_addr     = key_reg;
        unique case (state_reg)
            daqa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.look  = 1'b1;
                    state_next = daqa_pkg::S_BUSY;
                end
            end
            daqa_pkg::S_BUSY:
            begin
                in_stall = 1'b1;
                if (out_free)
                begin
                    state_next       = daqa_pkg::S_IDLE;
                    out_valid_next   = 1'b1;
                    queue_index_next = '0;
                    priority if (func_reg == daqa_pkg::FUNC_CLEAR)
                    begin
                        ctrl.clr         = 1'b1;
                        entry_count_next = '0;
                        status_next      = daqa_pkg::ST_CLEARED;
                    end
                    else if (!ipv4_reg)
                    begin
                        status_next = daqa_pkg::ST_NOMATCH;
                    end
                    else if (hit)
                    begin
                        status_next      = daqa_pkg::ST_HIT;
                        queue_index_next = hit_idx_w[5:0];
                    end
                    else if (full)
                    begin
                        status_next = daqa_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctrl.ins         = 1'b1;
                        ld_new           = 1'b1;
                        entry_count_next = entry_count_reg + 1'b1;
                        status_next      = daqa_pkg::ST_NEW;
                        queue_index_next = cnt_w[5:0];
                    end
                end
            end
            default:
            begin
                state_next = daqa_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= daqa_pkg::S_IDLE;
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg <= func;
            ipv4_reg <= is_ipv4;
            key_reg  <= dst_addr;
        end
        queue_index_reg <= queue_index_next;
        status_reg      <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign queue_index = queue_index_reg;
    assign status      = status_reg;

    // checks
    `DAQA_ASSERT_ALWAYS(a_count_tracks_valid, cnt_w == $countones(valid_vec))
    `DAQA_ASSERT_ALWAYS(a_single_match, $onehot0(match_vec))
    `DAQA_ASSERT_ALWAYS(a_valid_thermometer, !(valid_vec[0] == 1'b0 && full))
    `DAQA_ASSERT_NEXT(a_append_counts, ld_new, entry_count_reg == $past(entry_count_reg) + 1'b1)

endmodule

>>> hw/rtl/daqa_cell.sv
module daqa_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  daqa_pkg::cell_ctrl_t ctrl,
    input  logic                prev_valid,
    output logic                valid,
    output logic                match
);

    logic           valid_reg;
    logic           valid_next;
    logic           match_reg;
    logic           match_next;
    daqa_pkg::addr_t entry_reg;
    logic           wr_en;

    // this cell is the first free one when its neighbor holds an entry and it does not
    assign wr_en = ctrl.ins && prev_valid && !valid_reg;

    // valid bit and compare capture
    always_comb
    begin
        if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (wr_en)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg;
        end
        if (ctrl.look)
        begin
            match_next = valid_reg && (entry_reg == ctrl.look_addr);
        end
        else
        begin
            match_next = match_reg;
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    // stored address, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= ctrl.wr_addr;
        end
    end

    assign valid = valid_reg;
    assign match = match_reg;

endmodule

>>> hw/rtl/daqa_enc.sv
module daqa_enc (
    input  logic [daqa_pkg::TABLE_DEPTH-1:0] match_vec,
    output logic                             hit,
    output daqa_pkg::idx_t                   idx
);

    // at most one valid cell matches, so or-ing slot numbers gives the index
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < daqa_pkg::TABLE_DEPTH; i++)
        begin
            if (match_vec[i])
            begin
                idx = idx | daqa_pkg::idx_t'(i);
            end
        end
    end

    assign hit = |match_vec;

endmodule

>>> tb/daqa_result_checker.sv
module daqa_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        func,
    input  logic        is_ipv4,
    input  logic [31:0] dst_addr,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [5:0]  queue_index,
    input  logic [2:0]  status,
    output int          mismatches,
    output int          pending
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [5:0]          qidx;
        daqa_pkg::status_t   st;
    } assignment_t;

    // shadow of the association table
    daqa_pkg::addr_t seen_addr [daqa_pkg::TABLE_DEPTH];
    int              seen_count = 0;
    assignment_t     pending_assignments [$];
    int              error_count = 0;

    // queue assignment for one item, updating the shadow table
    function automatic assignment_t predict_assignment(logic f, logic v4,
                                                       daqa_pkg::addr_t a);
        assignment_t r;
        int          slot;
        r.qidx = '0;
        if (f == daqa_pkg::FUNC_CLEAR)
        begin
            seen_count = 0;
            r.st = daqa_pkg::ST_CLEARED;
            return r;
        end
        if (!v4)
        begin
            r.st = daqa_pkg::ST_NOMATCH;
            return r;
        end
        for (slot = 0; slot < seen_count; slot++)
        begin
            if (seen_addr[slot] == a)
            begin
                r.qidx = 6'(slot);
                r.st   = daqa_pkg::ST_HIT;
                return r;
            end
        end
        if (seen_count >= daqa_pkg::TABLE_DEPTH)
        begin
            r.st = daqa_pkg::ST_FULL;
            return r;
        end
        seen_addr[seen_count] = a;
        r.qidx = 6'(seen_count);
        r.st   = daqa_pkg::ST_NEW;
        seen_count++;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        assignment_t want;
        assignment_t got;
        if (!rst_n)
        begin
            seen_count = 0;
            pending_assignments.delete();
            error_count = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            // delivered item against the oldest expectation
            if (out_valid && !out_stall)
            begin
                got.qidx = queue_index;
                got.st   = daqa_pkg::status_t'(status);
                if (pending_assignments.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("unexpected item: queue_index %0d status %0d",
                                 queue_index, status);
                end
                else
                begin
                    want = pending_assignments.pop_front();
                    if (got.qidx !== want.qidx || got.st !== want.st)
                    begin
                        error_count++;
                        if (error_count <= REPORT_MAX)
                            $display("mismatch: qidx exp %0d got %0d, status exp %0d got %0d",
                                     want.qidx, got.qidx, want.st, status);
                    end
                end
            end
            // accepted item makes a new expectation
            if (in_valid && !in_stall)
                pending_assignments.push_back(predict_assignment(func, is_ipv4, dst_addr));
            mismatches <= error_count;
            pending    <= pending_assignments.size();
        end
    end

endmodule

>>> tb/tb_top.sv
module tb_top;

    localparam int RANDOM_ITEMS = 1400;
    localparam int POOL_N       = 96;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 6;

    typedef enum {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_e;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    logic            func;
    logic            is_ipv4;
    logic [31:0]     dst_addr;
    logic            out_valid;
    logic            out_stall;
    logic [5:0]      queue_index;
    logic [2:0]      status;
    int              mismatches;
    int              pending;
    int              cycles = 0;
    daqa_pkg::addr_t dest_pool [POOL_N];

    dest_addr_queue_assigner dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .is_ipv4     (is_ipv4),
        .dst_addr    (dst_addr),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .queue_index (queue_index),
        .status      (status)
    );

    daqa_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .is_ipv4     (is_ipv4),
        .dst_addr    (dst_addr),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .queue_index (queue_index),
        .status      (status),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // present one item and hold it until accepted
    task automatic send_item(input logic f, input logic v4, input daqa_pkg::addr_t a);
        in_valid <= 1'b1;
        func     <= f;
        is_ipv4  <= v4;
        dst_addr <= a;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // drop valid for a number of cycles, none when zero
    task automatic idle_for(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // receiver back-pressure, changing pattern now and then
    initial
    begin
        stall_mode_e mode;
        int          span;
        out_stall = 1'b0;
        forever
        begin
            mode = stall_mode_e'($urandom_range(0, 3));
            span = $urandom_range(4, 60);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial
    begin
        int              sent;
        int              burst;
        int              roll;
        int              pick;
        logic            f;
        logic            v4;
        daqa_pkg::addr_t a;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        func     = daqa_pkg::FUNC_CLASSIFY;
        is_ipv4  = 1'b0;
        dst_addr = '0;

        // address pool: small enough for hits, larger than the table
        foreach (dest_pool[k])
            dest_pool[k] = $urandom;
        dest_pool[0] = '0;
        dest_pool[1] = '1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: clear on empty, extremes, hits, stale entries after clear
        send_item(daqa_pkg::FUNC_CLEAR,    1'b0, '0);
        send_item(daqa_pkg::FUNC_CLASSIFY, 1'b0, 32'hFFFF_FFFF);
        send_item(daqa_pkg::FUNC_CLASSIFY, 1'b1, 32'h0000_0000);
        send_item(daqa_pkg::FUNC_CLASSIFY, 1'b1, 32'hFFFF_FFFF);
        idle_for($urandom_range(0, 2));
        send_item(daqa_pkg::FUNC_CLASSIFY, 1'b1, 32'h0000_0000);
        send_item(daqa_pkg::FUNC_CLASSIFY, 1'b1, 32'hFFFF_FFFF);
        send_item(daqa_pkg::FUNC_CLASSIFY, 1'b0, 32'h0000_0000);
        send_item(daqa_pkg::FUNC_CLASSIFY, 1'b1, 32'hAAAA_AAAA);
        idle_for($urandom_range(0, 2));
        send_item(daqa_pkg::FUNC_CLASSIFY, 1'b1, 32'h5555_5555);
        send_item(daqa_pkg::FUNC_CLASSIFY, 1'b1, 32'h8000_0000);
        send_item(daqa_pkg::FUNC_CLASSIFY, 1'b1, 32'h0000_0001);
        send_item(daqa_pkg::FUNC_CLASSIFY, 1'b1, 32'h5555_5555);
        idle_for($urandom_range(0, 2));
        send_item(daqa_pkg::FUNC_CLEAR,    1'b1, 32'hFFFF_FFFF);
        send_item(daqa_pkg::FUNC_CLASSIFY, 1'b1, 32'h5555_5555);
        send_item(daqa_pkg::FUNC_CLASSIFY, 1'b1, 32'h0000_0000);
        send_item(daqa_pkg::FUNC_CLASSIFY, 1'b1, 32'hFFFF_FFFF);
        send_item(daqa_pkg::FUNC_CLASSIFY, 1'b1, 32'h0000_0000);
        send_item(daqa_pkg::FUNC_CLASSIFY, 1'b0, 32'h5555_5555);
        send_item(daqa_pkg::FUNC_CLEAR,    1'b0, 32'hAAAA_AAAA);

        // random bursts: mostly pooled addresses so the table fills up
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 20);
            repeat (burst)
            begin
                roll = $urandom_range(0, 999);
                a    = $urandom;
                v4   = 1'b1;
                f    = daqa_pkg::FUNC_CLASSIFY;
                if (roll < 8)
                begin
                    f  = daqa_pkg::FUNC_CLEAR;
                    v4 = 1'($urandom_range(0, 1));
                end
                else if (roll < 100)
                    v4 = 1'b0;
                else
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                        a = dest_pool[$urandom_range(0, POOL_N - 1)];
                    else if (pick == 9)
                        a = ($urandom_range(0, 1) != 0) ? '1 : '0;
                end
                send_item(f, v4, a);
                sent++;
            end
            idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end

        // drain, then watch for stray results
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
